// ===== hdl/cpi_pkg.sv =====
// Shared types, constants and elaboration-time coefficient functions for the interpolator.
package cpi_pkg;

  localparam int FIELD_W = 16;  // width of each sample/result field on the ports
  localparam int PHASE_W = 4;   // width of the phase_index field

  // Window and sinc constants, Q30
  localparam longint Q30_PI  = 64'sd3373259426;
  localparam longint Q30_W42 = 64'sd450971566;
  localparam longint Q30_W08 = 64'sd85899346;

  // Sine polynomial coefficients, Q30
  localparam longint SIN_C1 = 64'sd1686629713;
  localparam longint SIN_C3 = 64'sd693598668;
  localparam longint SIN_C5 = 64'sd85569306;
  localparam longint SIN_C7 = 64'sd5026995;
  localparam longint SIN_C9 = 64'sd172272;

  typedef struct packed {
    logic load;    // shift a new sample in at the head of the ring
    logic rotate;  // circulate the ring by one place toward the head
  } cell_ctrl_t;

  typedef struct packed {
    logic               en;     // pipeline advance
    logic               valid;  // a tap product is issued this cycle
    logic               first;  // first tap of a phase
    logic               last;   // last tap of a phase
    logic [PHASE_W-1:0] phase;
  } mac_ctrl_t;

  typedef struct packed {
    logic               valid;  // accumulator holds a finished phase sum
    logic [PHASE_W-1:0] phase;
  } mac_done_t;

  // Shift-subtract division on non-negative operands, elaboration only
  function automatic longint cpi_udiv(input longint num, input longint den);
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    longint unsigned r;
    int              b;
    n = unsigned'(num);
    d = unsigned'(den);
    q = '0;
    r = '0;
    for (b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << b);
      end
    end
    return signed'(q);
  endfunction

  // Sine of a 16-bit turn fraction, Q30, polynomial per quadrant
  function automatic longint cpi_sin_q30(input longint turn);
    longint p;
    longint quad;
    longint x;
    longint z;
    longint z2;
    longint s;
    p    = turn & 64'sh0000_FFFF;
    quad = p >>> 14;
    x    = p & 64'sh0000_3FFF;
    if ((quad & 64'sd1) != 64'sd0) begin
      x = 64'sd16384 - x;
    end
    z  = x <<< 16;
    z2 = (z * z) >>> 30;
    s  = SIN_C9;
    s  = SIN_C7 - ((z2 * s) >>> 30);
    s  = SIN_C5 - ((z2 * s) >>> 30);
    s  = SIN_C3 - ((z2 * s) >>> 30);
    s  = SIN_C1 - ((z2 * s) >>> 30);
    s  = (z * s) >>> 30;
    return (quad >= 64'sd2) ? -s : s;
  endfunction

  // Q30 multiply, truncation on magnitudes
  function automatic longint cpi_q30_mul(input longint a, input longint b);
    logic   neg;
    longint ua;
    longint ub;
    longint p;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    p   = (ua * ub) >>> 30;
    return neg ? -p : p;
  endfunction

  // Unnormalized windowed-sinc tap i
  function automatic longint cpi_kernel_tmp(input int taps, input int up, input int i);
    longint klen;
    longint k;
    longint ak;
    longint ph;
    longint s;
    longint a1;
    longint a2;
    longint c1;
    longint c2;
    longint half;
    longint w;
    klen = longint'(taps) * longint'(up);
    k    = longint'(i) - (klen >>> 1);
    if (k == 0) begin
      s = cpi_udiv(Q30_PI, longint'(up));
    end else begin
      ak = (k < 0) ? -k : k;
      ph = cpi_udiv(ak * 64'sd32768 + (longint'(up) >>> 1), longint'(up));
      s  = cpi_sin_q30(ph);
      s  = (s < 0) ? -cpi_udiv(-s, ak) : cpi_udiv(s, ak);
    end
    a1   = cpi_udiv(longint'(i) * 64'sd65536 + (klen >>> 1), klen);
    a2   = cpi_udiv(longint'(i) * 64'sd131072 + (klen >>> 1), klen);
    c1   = cpi_sin_q30(a1 + 64'sd16384);
    c2   = cpi_sin_q30(a2 + 64'sd16384);
    half = (c1 < 0) ? -((-c1) >>> 1) : (c1 >>> 1);
    w    = Q30_W42 - half + cpi_q30_mul(Q30_W08, c2);
    if (w < 0) begin
      w = 0;
    end
    return cpi_q30_mul(s, w);
  endfunction

  function automatic longint cpi_kernel_sum(input int taps, input int up);
    longint sum;
    int     i;
    sum = 0;
    for (i = 0; i < taps * up; i++) begin
      sum = sum + cpi_kernel_tmp(taps, up, i);
    end
    return sum;
  endfunction

  // Normalized, rounded and saturated coefficient i
  function automatic longint cpi_coef(input int taps, input int up, input int cw,
                                      input int i, input longint sum);
    longint lim;
    longint t;
    longint mag;
    longint c;
    lim = longint'(1) <<< (cw - 1);
    c   = 0;
    if (sum > 0) begin
      t   = cpi_kernel_tmp(taps, up, i);
      mag = (t < 0) ? -t : t;
      c   = cpi_udiv(mag * lim + (sum >>> 1), sum);
      if (t < 0) begin
        c = -c;
      end
    end
    if (c > lim - 1) begin
      c = lim - 1;
    end
    if (c < -lim) begin
      c = -lim;
    end
    return c;
  endfunction

endpackage

// ===== hdl/complex_polyphase_interpolator.sv =====
// Top level: complex polyphase interpolating FIR, ring of delay cells feeding one complex MAC.
//
// Input stream (s_axis): one complex sample per word, sample_re in tdata[15:0] and sample_im
// in tdata[31:16]. Output stream (m_axis): UP_FACTOR words per input sample, one per phase,
// out_re in tdata[15:0], out_im in tdata[31:16], the phase number on tuser, and tlast on
// the final phase of each input sample.
// The delay line is a ring of TAPS_PER_PHASE cells. A new sample shifts in at the head; the
// ring then circulates once per phase so the head cell presents samples newest first to a
// single complex MAC, one tap per cycle unless stalled, paired with coefficient
// kernel[phase + tap*UP_FACTOR] from a constant table built at elaboration (Blackman-windowed
// sinc). The single MAC sets the throughput: a new sample is taken only after every phase of
// the previous one has been issued; s_axis_tready is high only while the ring is idle.
// Each phase sum passes through the operand, product and accumulate stages and then the
// output register; later phases follow as the ring circulates again.
// Reset clears the delay line to zero and empties the pipeline and output register.
// A stall on m_axis holds the finished result in the output register; the whole MAC pipeline
// and ring freeze only when a second result is ready and the register is still full.
module complex_polyphase_interpolator #(
  parameter int TAPS_PER_PHASE = 16,
  parameter int UP_FACTOR      = 4,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_WIDTH     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] sample_re, [31:16] sample_im
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] out_re, [31:16] out_im
  output logic [3:0]  m_axis_tuser_o,   // [3:0] phase_index
  output logic        m_axis_tlast_o    // last_of_run
);
  import cpi_pkg::*;

  localparam int KLEN = TAPS_PER_PHASE * UP_FACTOR;
  localparam int TW   = $clog2(TAPS_PER_PHASE);
  localparam int PW   = (UP_FACTOR > 1) ? $clog2(UP_FACTOR) : 1;
  localparam int KW   = $clog2(KLEN);
  // products plus growth over the taps, with a guard bit
  localparam int ACC_WIDTH = SAMPLE_WIDTH + COEF_WIDTH + TW + 1;
  localparam longint KSUM = cpi_kernel_sum(TAPS_PER_PHASE, UP_FACTOR);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // ---------------- coefficient table ----------------
  logic signed [COEF_WIDTH-1:0] coef_rom [KLEN];

  for (genvar gi = 0; gi < KLEN; gi++) begin : g_rom
    localparam logic signed [COEF_WIDTH-1:0] CoefVal =
      COEF_WIDTH'(cpi_coef(TAPS_PER_PHASE, UP_FACTOR, COEF_WIDTH, gi, KSUM));
    assign coef_rom[gi] = CoefVal;
  end

  // ---------------- input unpack ----------------
  // field bits above SAMPLE_WIDTH are ignored; a wider sample zero-extends the field
  logic [SAMPLE_WIDTH+FIELD_W-1:0] in_re_x, in_im_x;
  logic signed [SAMPLE_WIDTH-1:0]  in_re, in_im;

  assign in_re_x = {{SAMPLE_WIDTH{1'b0}}, s_axis_tdata_i[FIELD_W-1:0]};
  assign in_im_x = {{SAMPLE_WIDTH{1'b0}}, s_axis_tdata_i[2*FIELD_W-1:FIELD_W]};
  assign in_re   = in_re_x[SAMPLE_WIDTH-1:0];
  assign in_im   = in_im_x[SAMPLE_WIDTH-1:0];

  // ---------------- sequencer ----------------
  state_e          state_q;
  logic [TW-1:0]   tap_q;
  logic [PW-1:0]   phase_q;
  logic [KW-1:0]   caddr_q;   // phase + tap*UP_FACTOR
  logic            accept;
  logic            en;        // pipeline advance, low only on an output stall
  mac_done_t       done;
  cell_ctrl_t      cell_ctrl;
  mac_ctrl_t       mac_ctrl;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= '0;
      phase_q <= '0;
      caddr_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_RUN;
            tap_q   <= '0;
            phase_q <= '0;
            caddr_q <= '0;
          end
        end
        ST_RUN: begin
          if (en) begin
            if (tap_q == TW'(TAPS_PER_PHASE - 1)) begin
              tap_q <= '0;
              if (phase_q == PW'(UP_FACTOR - 1)) begin
                state_q <= ST_IDLE;
                phase_q <= '0;
                caddr_q <= '0;
              end else begin
                phase_q <= phase_q + PW'(1);
                caddr_q <= KW'(phase_q) + KW'(1);
              end
            end else begin
              tap_q   <= tap_q + TW'(1);
              caddr_q <= caddr_q + KW'(UP_FACTOR);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------- delay ring ----------------
  logic signed [SAMPLE_WIDTH-1:0] cell_re [TAPS_PER_PHASE];
  logic signed [SAMPLE_WIDTH-1:0] cell_im [TAPS_PER_PHASE];

  assign cell_ctrl.load   = accept;
  assign cell_ctrl.rotate = (state_q == ST_RUN) && en;

  for (genvar gc = 0; gc < TAPS_PER_PHASE; gc++) begin : g_cell
    localparam int PrevIdx = (gc + TAPS_PER_PHASE - 1) % TAPS_PER_PHASE;
    localparam int NextIdx = (gc + 1) % TAPS_PER_PHASE;
    cpi_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .prev_re_i((gc == 0) ? in_re : cell_re[PrevIdx]),
      .prev_im_i((gc == 0) ? in_im : cell_im[PrevIdx]),
      .next_re_i(cell_re[NextIdx]),
      .next_im_i(cell_im[NextIdx]),
      .re_o     (cell_re[gc]),
      .im_o     (cell_im[gc])
    );
  end

  // ---------------- MAC ----------------
  logic [FIELD_W-1:0] mac_re, mac_im;

  assign mac_ctrl.en    = en;
  assign mac_ctrl.valid = (state_q == ST_RUN);
  assign mac_ctrl.first = (tap_q == '0);
  assign mac_ctrl.last  = (tap_q == TW'(TAPS_PER_PHASE - 1));
  assign mac_ctrl.phase = PHASE_W'(phase_q);

  cpi_mac #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .sample_re_i(cell_re[0]),
    .sample_im_i(cell_im[0]),
    .coef_i     (coef_rom[caddr_q]),
    .done_o     (done),
    .out_re_o   (mac_re),
    .out_im_o   (mac_im)
  );

  // ---------------- output register ----------------
  logic               out_valid_q;
  logic [FIELD_W-1:0] out_re_q, out_im_q;
  logic [PHASE_W-1:0] out_phase_q;
  logic               out_last_q;

  assign en = !(done.valid && out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done.valid && en) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done.valid && en) begin
      out_re_q    <= mac_re;
      out_im_q    <= mac_im;
      out_phase_q <= done.phase;
      out_last_q  <= (done.phase == PHASE_W'(UP_FACTOR - 1));
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_im_q, out_re_q};
  assign m_axis_tuser_o  = out_phase_q;
  assign m_axis_tlast_o  = out_last_q;

  // ---------------- assertions ----------------
  // a taken sample starts a run on the next cycle
  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> state_q == ST_RUN)
    else $error("accepted sample did not start a run");

  // coefficient address tracks phase and tap
  a_caddr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |->
      caddr_q == KW'(phase_q) + KW'(tap_q) * KW'(UP_FACTOR))
    else $error("coefficient address out of step with phase and tap");

  // tlast marks exactly the final phase
  a_last_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tlast_o == (m_axis_tuser_o == 4'(UP_FACTOR - 1)))
    else $error("tlast does not match the final phase");

endmodule

// ===== hdl/cpi_cell.sv =====
// One delay-line cell: holds a complex sample, loads from its tail-side or head-side neighbor.
module cpi_cell #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cpi_pkg::cell_ctrl_t            ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_re_i,  // head-side neighbor (shift in)
  input  logic signed [SAMPLE_WIDTH-1:0] prev_im_i,
  input  logic signed [SAMPLE_WIDTH-1:0] next_re_i,  // tail-side neighbor (rotate)
  input  logic signed [SAMPLE_WIDTH-1:0] next_im_i,
  output logic signed [SAMPLE_WIDTH-1:0] re_o,
  output logic signed [SAMPLE_WIDTH-1:0] im_o
);
  import cpi_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] re_q, im_q;

  // delay line is architectural state: cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_q <= '0;
      im_q <= '0;
    end else if (ctrl_i.load) begin
      re_q <= prev_re_i;
      im_q <= prev_im_i;
    end else if (ctrl_i.rotate) begin
      re_q <= next_re_i;
      im_q <= next_im_i;
    end
  end

  assign re_o = re_q;
  assign im_o = im_q;

endmodule

// ===== hdl/cpi_mac.sv =====
// Complex-by-real multiply-accumulate pipeline with rounding and saturation.
module cpi_mac #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16,
  parameter int ACC_WIDTH    = 37
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cpi_pkg::mac_ctrl_t             ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_re_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_im_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_i,
  output cpi_pkg::mac_done_t             done_o,
  output logic [cpi_pkg::FIELD_W-1:0]    out_re_o,
  output logic [cpi_pkg::FIELD_W-1:0]    out_im_o
);
  import cpi_pkg::*;

  localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
  localparam logic signed [ACC_WIDTH-1:0] RND    = ACC_WIDTH'(1) <<< (COEF_WIDTH - 2);
  localparam logic signed [ACC_WIDTH-1:0] SAT_HI =
    ACC_WIDTH'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [ACC_WIDTH-1:0] SAT_LO = ~SAT_HI;

  // stage 1: operands
  logic                           v1_q, f1_q, l1_q;
  logic [PHASE_W-1:0]             ph1_q;
  logic signed [SAMPLE_WIDTH-1:0] re1_q, im1_q;
  logic signed [COEF_WIDTH-1:0]   c1_q;
  // stage 2: products
  logic                           v2_q, f2_q, l2_q;
  logic [PHASE_W-1:0]             ph2_q;
  logic signed [PW-1:0]           pre2_q, pim2_q;
  // stage 3: accumulators
  logic                           v3_q, l3_q;
  logic [PHASE_W-1:0]             ph3_q;
  logic signed [ACC_WIDTH-1:0]    acc_re_q, acc_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (ctrl_i.en) begin
      v1_q <= ctrl_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      f1_q   <= ctrl_i.first;
      l1_q   <= ctrl_i.last;
      ph1_q  <= ctrl_i.phase;
      re1_q  <= sample_re_i;
      im1_q  <= sample_im_i;
      c1_q   <= coef_i;
      f2_q   <= f1_q;
      l2_q   <= l1_q;
      ph2_q  <= ph1_q;
      pre2_q <= re1_q * c1_q;
      pim2_q <= im1_q * c1_q;
      l3_q   <= l2_q;
      ph3_q  <= ph2_q;
      if (v2_q) begin
        acc_re_q <= f2_q ? ACC_WIDTH'(pre2_q) : acc_re_q + ACC_WIDTH'(pre2_q);
        acc_im_q <= f2_q ? ACC_WIDTH'(pim2_q) : acc_im_q + ACC_WIDTH'(pim2_q);
      end
    end
  end

  // round half up, saturate to the sample range, sign-extend to the field
  function automatic logic [FIELD_W-1:0] round_sat(input logic signed [ACC_WIDTH-1:0] a);
    logic signed [ACC_WIDTH-1:0]       r;
    logic signed [SAMPLE_WIDTH-1:0]    s;
    logic signed [SAMPLE_WIDTH+FIELD_W-1:0] x;
    r = (a + RND) >>> (COEF_WIDTH - 1);
    if (r > SAT_HI) begin
      s = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (r < SAT_LO) begin
      s = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      s = r[SAMPLE_WIDTH-1:0];
    end
    x = (SAMPLE_WIDTH + FIELD_W)'(s);
    return x[FIELD_W-1:0];
  endfunction

  assign done_o.valid = v3_q && l3_q;
  assign done_o.phase = ph3_q;
  assign out_re_o     = round_sat(acc_re_q);
  assign out_im_o     = round_sat(acc_im_q);

endmodule
